>>> rtl/gae_pkg.sv
// Package for the gain automation envelope core.
// Holds the fixed field widths, status and function codes, and the event record type.
// No dependencies.
package gae_pkg;

   // Default values for the top level parameters.
   localparam int EVENT_SLOTS_DEF    = 32;
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int GAIN_FRAC_BITS_DEF = 16;

   // Fixed widths of the event fields.
   localparam int GAIN_BITS  = 32;
   localparam int START_BITS = 48;
   localparam int COEFF_BITS = 24;

   // The shared multiplier takes two signed operands of this width.
   localparam int MUL_BITS = GAIN_BITS + 1;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_DONE   = 2'd0;
   localparam status_type STATUS_SAT    = 2'd1;
   localparam status_type STATUS_ACCEPT = 2'd2;
   localparam status_type STATUS_REJECT = 2'd3;

   localparam logic FUNC_SAMPLE   = 1'b0;
   localparam logic FUNC_SCHEDULE = 1'b1;

   typedef struct packed {
      logic signed [GAIN_BITS-1:0] gain;
      logic [START_BITS-1:0]       start;
      logic [COEFF_BITS-1:0]       coeff;
   } event_type;

endpackage

>>> rtl/gae_req_if.sv
// Request channel of the gain automation envelope core.
// Carries one sample or schedule item per transfer; depends on gae_pkg.
interface gae_req_if #(
   parameter int SAMPLE_BITS = gae_pkg::SAMPLE_BITS_DEF
) ();
   logic                                  valid;
   logic                                  ready;
   logic                                  func;
   logic signed [SAMPLE_BITS-1:0]         in_left;
   logic signed [SAMPLE_BITS-1:0]         in_right;
   logic signed [gae_pkg::GAIN_BITS-1:0]  event_gain;
   logic [gae_pkg::START_BITS-1:0]        event_start;
   logic [gae_pkg::COEFF_BITS-1:0]        event_coeff;

   modport source (
      output valid, func, in_left, in_right, event_gain, event_start, event_coeff,
      input  ready
   );

   modport sink (
      input  valid, func, in_left, in_right, event_gain, event_start, event_coeff,
      output ready
   );
endinterface

>>> rtl/gae_rsp_if.sv
// Response channel of the gain automation envelope core.
// Carries one result per transfer; depends on gae_pkg.
interface gae_rsp_if #(
   parameter int SAMPLE_BITS = gae_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_left;
   logic signed [SAMPLE_BITS-1:0] out_right;
   gae_pkg::status_type           status;

   modport source (
      output valid, out_left, out_right, status,
      input  ready
   );

   modport sink (
      input  valid, out_left, out_right, status,
      output ready
   );
endinterface

>>> rtl/gain_automation_envelope_core.sv
// Gain automation envelope core: stereo gain stage driven by a sorted event list.
// Depends on gae_pkg, gae_req_if and gae_rsp_if.
//
// A schedule transfer (func = 1) inserts a gain event into a list kept in start
// order in a circular event memory, ties after earlier arrivals; a full list
// drops the event and reports status 3. A sample transfer (func = 0) first
// retires every event whose start is at or before the running sample count,
// then scales both channels by the current Q16.16 gain with saturation, then
// moves the gain one smoothing step toward the target when smoothing is active.
// The block takes one item at a time and holds req_ch.ready low while it works.
// A schedule item walks from the tail toward the head, moving each entry that
// starts later up one slot to make room (at most EVENT_SLOTS - 1 entries), then
// writes the new event; the single read and the single write port of the event
// memory serialise this walk. A rejected event goes straight to the result.
// A sample item reads and retires due events from the head one by one, then
// scales left and right and, when smoothing is active, takes the step; the single
// shared 33 x 33 multiplier serves left, right and the smoothing step in turn.
// The result sits in an output register, so the next item is taken while it
// waits; a result only stalls the block when the previous one is still unread.
// The event memory needs no clearing pass after reset: the fill count guards it.
module gain_automation_envelope_core #(
   parameter int EVENT_SLOTS    = gae_pkg::EVENT_SLOTS_DEF,
   parameter int SAMPLE_BITS    = gae_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = gae_pkg::GAIN_FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   gae_req_if.sink   req_ch,
   gae_rsp_if.source rsp_ch
);

   localparam int IDXW  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int FILLW = $clog2(EVENT_SLOTS + 1);
   localparam int GW    = gae_pkg::GAIN_BITS;
   localparam int SW    = gae_pkg::START_BITS;
   localparam int CW    = gae_pkg::COEFF_BITS;
   localparam int MW    = gae_pkg::MUL_BITS;
   localparam int PW    = 2 * MW;

   localparam logic [FILLW-1:0] FILL_FULL = FILLW'(EVENT_SLOTS);
   localparam logic [IDXW:0]    SLOTS_W   = (IDXW + 1)'(EVENT_SLOTS);

   localparam logic signed [PW-1:0] SAT_HI =
      {{(PW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;
   localparam logic [PW-1:0] BIAS_GAIN  = {{(PW - GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};
   localparam logic [PW-1:0] BIAS_COEFF = {{(PW - CW){1'b0}}, {CW{1'b1}}};

   localparam logic signed [GW-1:0] UNITY_GAIN = GW'(1 << GAIN_FRAC_BITS);

   // Sequencer states.
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INS_CHK = 4'd1;
   localparam logic [3:0] S_INS_WR  = 4'd2;
   localparam logic [3:0] S_POP_CHK = 4'd3;
   localparam logic [3:0] S_MUL_L   = 4'd4;
   localparam logic [3:0] S_MUL_R   = 4'd5;
   localparam logic [3:0] S_SAT_R   = 4'd6;
   localparam logic [3:0] S_SMTH_M  = 4'd7;
   localparam logic [3:0] S_SMTH_Q  = 4'd8;
   localparam logic [3:0] S_SMTH_A  = 4'd9;
   localparam logic [3:0] S_FINISH  = 4'd10;

   // Add two list offsets modulo the slot count.
   function automatic logic [IDXW-1:0] wrap_add(input logic [IDXW-1:0] a,
                                                input logic [IDXW-1:0] b);
      logic [IDXW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= SLOTS_W) begin
         s = s - SLOTS_W;
      end
      return s[IDXW-1:0];
   endfunction

   // Control state.
   logic [3:0]              state_ff, state_in;
   logic [FILLW-1:0]        fill_ff, fill_in;
   logic [IDXW-1:0]         head_ff, head_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [GW-1:0]    current_gain_ff, current_gain_in;
   logic signed [GW-1:0]    target_gain_ff, target_gain_in;
   logic [CW-1:0]           active_coeff_ff, active_coeff_in;
   logic [SW-1:0]           sample_count_ff, sample_count_in;

   // Payload and working registers.
   logic                          item_func_ff;
   logic signed [SAMPLE_BITS-1:0] item_left_ff, item_right_ff;
   gae_pkg::event_type            item_event_ff;
   logic [IDXW-1:0]               pos_ff, pos_in;
   logic signed [PW-1:0]          product_ff;
   logic signed [MW-1:0]          q_ff;
   logic                          sat_ff, sat_in;
   logic signed [SAMPLE_BITS-1:0] res_left_ff, res_left_in;
   logic signed [SAMPLE_BITS-1:0] res_right_ff, res_right_in;
   gae_pkg::status_type           res_status_ff, res_status_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_right_ff;
   gae_pkg::status_type           rsp_status_ff;

   // Event memory.
   gae_pkg::event_type event_mem [EVENT_SLOTS];
   gae_pkg::event_type rd_data_ff;
   gae_pkg::event_type wr_data;
   logic               wr_en, rd_en;
   logic [IDXW-1:0]    wr_addr, rd_addr;

   // Shared multiplier and rounding unit.
   logic                 mul_en;
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] product_in;
   logic                 round_coeff;
   logic signed [PW-1:0] round_sum, rnd;
   logic                 clip_hi, clip_lo;
   logic signed [SAMPLE_BITS-1:0] clipped;
   logic signed [MW-1:0] gain_sum;

   logic req_xfer, rsp_free;
   logic [IDXW-1:0] pos_m1, pos_m2;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_left  = rsp_left_ff;
   assign rsp_ch.out_right = rsp_right_ff;
   assign rsp_ch.status    = rsp_status_ff;

   assign pos_m1 = pos_ff - IDXW'(1);
   assign pos_m2 = pos_ff - IDXW'(2);

   // Select the multiplier operands: left, right, then the smoothing difference.
   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         S_MUL_L: begin
            mul_en = 1'b1;
            mul_a  = MW'(item_left_ff);
            mul_b  = MW'(current_gain_ff);
         end
         S_MUL_R: begin
            mul_en = 1'b1;
            mul_a  = MW'(item_right_ff);
            mul_b  = MW'(current_gain_ff);
         end
         S_SMTH_M: begin
            mul_en = 1'b1;
            mul_a  = MW'(current_gain_ff) - MW'(target_gain_ff);
            mul_b  = signed'(MW'(active_coeff_ff));
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign product_in = mul_a * mul_b;

   // Shift right rounding toward zero: bias negative products before the shift.
   assign round_coeff = (state_ff == S_SMTH_Q);
   assign round_sum   = product_ff + (product_ff[PW-1]
                                      ? signed'(round_coeff ? BIAS_COEFF : BIAS_GAIN)
                                      : signed'(PW'(0)));
   assign rnd         = round_coeff ? (round_sum >>> CW) : (round_sum >>> GAIN_FRAC_BITS);

   // Saturate the scaled sample.
   assign clip_hi = (rnd > SAT_HI);
   assign clip_lo = (rnd < SAT_LO);
   assign clipped = clip_hi ? SAMPLE_BITS'(SAT_HI)
                  : clip_lo ? SAMPLE_BITS'(SAT_LO)
                  : SAMPLE_BITS'(rnd);

   // Smoothing step lands between the old gain and the target, so 32 bits hold it.
   assign gain_sum = MW'(target_gain_ff) + q_ff;

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      head_in         = head_ff;
      rsp_valid_in    = rsp_valid_ff;
      current_gain_in = current_gain_ff;
      target_gain_in  = target_gain_ff;
      active_coeff_in = active_coeff_ff;
      sample_count_in = sample_count_ff;
      pos_in          = pos_ff;
      sat_in          = sat_ff;
      res_left_in     = res_left_ff;
      res_right_in    = res_right_ff;
      res_status_in   = res_status_ff;
      wr_en           = 1'b0;
      wr_addr         = wrap_add(head_ff, pos_ff);
      wr_data         = item_event_ff;
      rd_en           = 1'b0;
      rd_addr         = head_ff;

      // Drop the result register once the sink takes it.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_ch.func == gae_pkg::FUNC_SCHEDULE) begin
                  res_left_in  = '0;
                  res_right_in = '0;
                  pos_in       = fill_ff[IDXW-1:0];
                  if (fill_ff >= FILL_FULL) begin
                     res_status_in = gae_pkg::STATUS_REJECT;
                     state_in      = S_FINISH;
                  end else if (fill_ff == '0) begin
                     state_in = S_INS_WR;
                  end else begin
                     // Fetch the last entry to start the walk toward the head.
                     rd_en    = 1'b1;
                     rd_addr  = wrap_add(head_ff, fill_ff[IDXW-1:0] - IDXW'(1));
                     state_in = S_INS_CHK;
                  end
               end else begin
                  if (fill_ff != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     state_in = S_POP_CHK;
                  end else begin
                     state_in = S_MUL_L;
                  end
               end
            end
         end

         S_INS_CHK: begin
            // rd_data_ff holds entry pos - 1; move it up if it starts later.
            if (rd_data_ff.start > item_event_ff.start) begin
               wr_en   = 1'b1;
               wr_addr = wrap_add(head_ff, pos_ff);
               wr_data = rd_data_ff;
               pos_in  = pos_m1;
               if (pos_ff > IDXW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = wrap_add(head_ff, pos_m2);
               end else begin
                  state_in = S_INS_WR;
               end
            end else begin
               state_in = S_INS_WR;
            end
         end

         S_INS_WR: begin
            wr_en         = 1'b1;
            wr_addr       = wrap_add(head_ff, pos_ff);
            wr_data       = item_event_ff;
            fill_in       = fill_ff + FILLW'(1);
            res_status_in = gae_pkg::STATUS_ACCEPT;
            state_in      = S_FINISH;
         end

         S_POP_CHK: begin
            // rd_data_ff holds the head entry; retire it when due.
            if (rd_data_ff.start <= sample_count_ff) begin
               target_gain_in  = rd_data_ff.gain;
               active_coeff_in = rd_data_ff.coeff;
               if (rd_data_ff.coeff == '0) begin
                  current_gain_in = rd_data_ff.gain;
               end
               head_in = wrap_add(head_ff, IDXW'(1));
               fill_in = fill_ff - FILLW'(1);
               if (fill_ff > FILLW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = wrap_add(head_ff, IDXW'(1));
               end else begin
                  state_in = S_MUL_L;
               end
            end else begin
               state_in = S_MUL_L;
            end
         end

         S_MUL_L: begin
            state_in = S_MUL_R;
         end

         S_MUL_R: begin
            res_left_in = clipped;
            sat_in      = clip_hi || clip_lo;
            state_in    = S_SAT_R;
         end

         S_SAT_R: begin
            res_right_in  = clipped;
            res_status_in = (sat_ff || clip_hi || clip_lo) ? gae_pkg::STATUS_SAT
                                                         : gae_pkg::STATUS_DONE;
            if (active_coeff_ff != '0) begin
               state_in = S_SMTH_M;
            end else begin
               sample_count_in = sample_count_ff + SW'(1);
               state_in        = S_FINISH;
            end
         end

         S_SMTH_M: begin
            state_in = S_SMTH_Q;
         end

         S_SMTH_Q: begin
            state_in = S_SMTH_A;
         end

         S_SMTH_A: begin
            current_gain_in = gain_sum[GW-1:0];
            sample_count_in = sample_count_ff + SW'(1);
            state_in        = S_FINISH;
         end

         S_FINISH: begin
            // Hold until the result register is free, then load it.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         fill_ff         <= '0;
         head_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         current_gain_ff <= UNITY_GAIN;
         target_gain_ff  <= UNITY_GAIN;
         active_coeff_ff <= '0;
         sample_count_ff <= '0;
      end else begin
         state_ff        <= state_in;
         fill_ff         <= fill_in;
         head_ff         <= head_in;
         rsp_valid_ff    <= rsp_valid_in;
         current_gain_ff <= current_gain_in;
         target_gain_ff  <= target_gain_in;
         active_coeff_ff <= active_coeff_in;
         sample_count_ff <= sample_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_func_ff        <= req_ch.func;
         item_left_ff        <= req_ch.in_left;
         item_right_ff       <= req_ch.in_right;
         item_event_ff.gain  <= req_ch.event_gain;
         item_event_ff.start <= req_ch.event_start;
         item_event_ff.coeff <= req_ch.event_coeff;
      end
      if (mul_en) begin
         product_ff <= product_in;
      end
      if (state_ff == S_SMTH_Q) begin
         q_ff <= rnd[MW-1:0];
      end
      pos_ff        <= pos_in;
      sat_ff        <= sat_in;
      res_left_ff   <= res_left_in;
      res_right_ff  <= res_right_in;
      res_status_ff <= res_status_in;
      if (state_ff == S_FINISH && rsp_free) begin
         rsp_left_ff   <= res_left_ff;
         rsp_right_ff  <= res_right_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         event_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= event_mem[rd_addr];
      end
   end

`ifndef SYNTH
   // The list never holds more events than there are slots.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("event list fill count above slot count");

   // An insert grows the list by exactly one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_WR) |=> (fill_ff == $past(fill_ff) + FILLW'(1)))
      else $error("insert did not grow the event list by one");

   // A retired event shrinks the list by one and advances the head.
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP_CHK && rd_data_ff.start <= sample_count_ff)
      |=> (fill_ff == $past(fill_ff) - FILLW'(1)) && (head_ff != $past(head_ff)
           || EVENT_SLOTS == 1))
      else $error("event retire did not update fill and head");

   // A schedule transfer on a full list reports a reject.
   a_full_rejects: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.func == gae_pkg::FUNC_SCHEDULE && fill_ff >= FILL_FULL)
      |=> (res_status_ff == gae_pkg::STATUS_REJECT) && (state_ff == S_FINISH))
      else $error("full event list did not reject the event");

   // Schedule items never advance the sample count.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_WR || (state_ff == S_FINISH && item_func_ff))
      |=> $stable(sample_count_ff))
      else $error("sample count moved on a schedule item");
`endif

endmodule
